// File: rtl/pcxs_pkg.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler package
// Shared constants, the parser phase type, the queue entry and the key and
// lead byte tables.
// ----------------------------------------------------------------------------
package pcxs_pkg;

    localparam int KEY_BYTES     = 42;
    localparam int NAME_LEN_BITS = 16;
    localparam int IDAT_LIMIT    = 39;

    localparam logic [31:0] KIND_PLTE  = 32'h504C5445;
    localparam logic [31:0] KIND_IDAT  = 32'h49444154;
    localparam logic [7:0]  UNDERSCORE = 8'h5F;

    typedef logic [5:0] key_idx_t;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_HEAD,
        PH_DATA,
        PH_CRC,
        PH_TAIL,
        PH_RAW
    } phase_t;

    // One queue entry: a run of result bytes. Bytes before the final one come
    // from the lead table starting at start; the final one is data.
    typedef struct packed {
        logic [3:0] start;
        logic [3:0] cnt;
        logic [7:0] data;
        logic       handled;
        logic       file_last;
    } pcxs_op_t;

    function automatic logic [7:0] key_base(input key_idx_t i);
        logic [7:0] r;
        case (i)
            6'd0:  r = 8'h9d;  6'd1:  r = 8'hF3;  6'd2:  r = 8'h00;  6'd3:  r = 8'h25;
            6'd4:  r = 8'hef;  6'd5:  r = 8'h02;  6'd6:  r = 8'h77;  6'd7:  r = 8'hfd;
            6'd8:  r = 8'he3;  6'd9:  r = 8'h39;  6'd10: r = 8'hcd;  6'd11: r = 8'h02;
            6'd12: r = 8'h98;  6'd13: r = 8'h67;  6'd14: r = 8'h25;  6'd15: r = 8'hDC;
            6'd16: r = 8'h10;  6'd17: r = 8'h95;  6'd18: r = 8'h68;  6'd19: r = 8'h69;
            6'd20: r = 8'h49;  6'd21: r = 8'h56;  6'd22: r = 8'h75;  6'd23: r = 8'h20;
            6'd24: r = 8'h85;  6'd25: r = 8'h39;  6'd26: r = 8'h99;  6'd27: r = 8'hDF;
            6'd28: r = 8'hF6;  6'd29: r = 8'h7E;  6'd30: r = 8'h70;  6'd31: r = 8'h95;
            6'd32: r = 8'he8;  6'd33: r = 8'hCC;  6'd34: r = 8'hEF;  6'd35: r = 8'h40;
            6'd36: r = 8'h79;  6'd37: r = 8'h99;  6'd38: r = 8'hd1;  6'd39: r = 8'hae;
            6'd40: r = 8'h76;  6'd41: r = 8'h9F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // The tag followed by the PNG signature.
    function automatic logic [7:0] lead_byte(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:  r = 8'h99;  4'd1:  r = 8'h46;  4'd2:  r = 8'hB8;  4'd3:  r = 8'h0D;
            4'd4:  r = 8'h89;  4'd5:  r = 8'h50;  4'd6:  r = 8'h4E;  4'd7:  r = 8'h47;
            4'd8:  r = 8'h0D;  4'd9:  r = 8'h0A;  4'd10: r = 8'h1A;  4'd11: r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/pcxs_front.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler front end
// Takes name characters and file bytes, keeps the key text, walks the PNG
// structure and queues runs of result bytes, holding back partial signatures.
// ----------------------------------------------------------------------------
module pcxs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [7:0]          value,
    input  logic                last,
    output logic                op_push,
    output pcxs_pkg::pcxs_op_t  op,
    input  logic                op_full
);
    import pcxs_pkg::*;

    logic                     dir_reg;
    logic                     file_dir_reg, file_dir_next;
    phase_t                   phase_reg, phase_next;
    logic [31:0]              fc_reg, fc_next;
    logic [31:0]              clen_reg, clen_next;
    logic [31:0]              ckind_reg, ckind_next;
    key_idx_t                 kp_reg, kp_next;
    logic [NAME_LEN_BITS-1:0] nlen_reg, nlen_next;
    logic [NAME_LEN_BITS-1:0] upos_reg, upos_next;
    logic                     useen_reg, useen_next;
    logic                     closed_reg, closed_next;

    logic [7:0] name_mem [KEY_BYTES];
    logic [7:0] suf_mem  [KEY_BYTES];
    logic [7:0] name_rd_reg, suf_rd_reg;
    logic       hit_reg, suf_sel_reg;

    logic                     accept;
    logic [NAME_LEN_BITS-1:0] eff_len, eff_upos, sfx_k;
    logic                     eff_useen, name_we, suf_we, under_hit;
    logic                     use_suf;
    logic [NAME_LEN_BITS-1:0] nfull;
    key_idx_t                 tn, mirror, rd_addr;
    logic [7:0]               key_byte;
    logic                     fdir;
    logic [3:0]               base, need, hi, hcnt;
    logic [32:0]              fc_inc;
    logic [31:0]              len_cut;

    assign accept   = in_valid && in_ready;
    assign in_ready = !op_full;

    assign eff_len   = closed_reg ? '0 : nlen_reg;
    assign eff_upos  = closed_reg ? '0 : upos_reg;
    assign eff_useen = closed_reg ? 1'b0 : useen_reg;
    assign under_hit = !eff_useen && (value == UNDERSCORE);
    assign sfx_k     = eff_len - eff_upos - NAME_LEN_BITS'(1);
    assign name_we   = accept && !command && (eff_len < NAME_LEN_BITS'(KEY_BYTES));
    assign suf_we    = accept && !command && eff_useen && (eff_len > eff_upos)
                       && (sfx_k < NAME_LEN_BITS'(KEY_BYTES));

    assign use_suf = useen_reg &&
                     (({1'b0, upos_reg} + (NAME_LEN_BITS+1)'(1)) < {1'b0, nlen_reg});
    assign nfull   = use_suf ? (nlen_reg - upos_reg - NAME_LEN_BITS'(1)) : nlen_reg;
    assign tn      = (nfull >= NAME_LEN_BITS'(KEY_BYTES)) ? key_idx_t'(KEY_BYTES)
                                                          : nfull[5:0];
    assign mirror  = key_idx_t'(KEY_BYTES - 1) - kp_next;
    assign rd_addr = (mirror < tn) ? mirror : kp_next;

    assign key_byte = key_base(kp_reg) ^
                      (hit_reg ? (suf_sel_reg ? suf_rd_reg : name_rd_reg) : 8'h00);

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[eff_len[5:0]] <= value;
        end
        if (suf_we)
        begin
            suf_mem[sfx_k[5:0]] <= value;
        end
        name_rd_reg <= name_mem[rd_addr];
        suf_rd_reg  <= suf_mem[rd_addr];
        hit_reg     <= rd_addr < tn;
        suf_sel_reg <= use_suf;
    end

    always_comb
    begin
        file_dir_next = file_dir_reg;
        phase_next    = phase_reg;
        fc_next       = fc_reg;
        clen_next     = clen_reg;
        ckind_next    = ckind_reg;
        kp_next       = kp_reg;
        nlen_next     = nlen_reg;
        upos_next     = upos_reg;
        useen_next    = useen_reg;
        closed_next   = closed_reg;
        op_push       = 1'b0;
        op            = '{start: 4'd0, cnt: 4'd1, data: value, handled: 1'b1,
                          file_last: last};
        fdir          = (fc_reg == 32'd0) ? dir_reg : file_dir_reg;
        base          = fdir ? 4'd0 : 4'd4;
        need          = fdir ? 4'd12 : 4'd8;
        hi            = (fc_reg >= {28'd0, need}) ? (need - 4'd1) : fc_reg[3:0];
        hcnt          = hi + 4'd1;
        fc_inc        = {1'b0, fc_reg} + 33'd1;
        len_cut       = (clen_reg > 32'(IDAT_LIMIT)) ? 32'(IDAT_LIMIT) : clen_reg;
        if (accept && !command)
        begin
            nlen_next   = eff_len + ((eff_len != '1) ? NAME_LEN_BITS'(1) : '0);
            upos_next   = under_hit ? eff_len : eff_upos;
            useen_next  = eff_useen || under_hit;
            closed_next = last;
            phase_next  = PH_SIG;
            fc_next     = '0;
        end
        else if (accept)
        begin
            op_push = 1'b1;
            unique case (phase_reg)
                PH_SIG:
                begin
                    if (fc_reg == 32'd0)
                    begin
                        file_dir_next = dir_reg;
                    end
                    fc_next = {28'd0, hcnt};
                    if (lead_byte(base + hi) != value)
                    begin
                        op.start   = base;
                        op.cnt     = hcnt;
                        op.handled = 1'b0;
                        phase_next = PH_RAW;
                    end
                    else if (hcnt == need)
                    begin
                        op.start   = fdir ? 4'd4 : 4'd0;
                        op.cnt     = fdir ? 4'd8 : 4'd12;
                        phase_next = PH_HEAD;
                        fc_next    = '0;
                        clen_next  = '0;
                        ckind_next = '0;
                    end
                    else if (last)
                    begin
                        op.start   = base;
                        op.cnt     = hcnt;
                        op.handled = 1'b0;
                    end
                    else
                    begin
                        op_push = 1'b0;
                    end
                end
                PH_HEAD:
                begin
                    if (fc_reg < 32'd4)
                    begin
                        clen_next = {clen_reg[23:0], value};
                    end
                    else
                    begin
                        ckind_next = {ckind_reg[23:0], value};
                    end
                    fc_next = fc_inc[31:0];
                    if (fc_inc >= 33'd8)
                    begin
                        fc_next = '0;
                        kp_next = '0;
                        if (ckind_next == KIND_IDAT)
                        begin
                            clen_next  = len_cut;
                            phase_next = (len_cut != 32'd0) ? PH_DATA : PH_TAIL;
                        end
                        else
                        begin
                            phase_next = (clen_reg != 32'd0) ? PH_DATA : PH_CRC;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (ckind_reg == KIND_PLTE || ckind_reg == KIND_IDAT)
                    begin
                        op.data = value ^ key_byte;
                    end
                    kp_next = (kp_reg == key_idx_t'(KEY_BYTES - 1)) ? '0 : kp_reg + 6'd1;
                    fc_next = fc_inc[31:0];
                    if (fc_inc >= {1'b0, clen_reg})
                    begin
                        fc_next    = '0;
                        phase_next = (ckind_reg == KIND_IDAT) ? PH_TAIL : PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    fc_next = fc_inc[31:0];
                    if (fc_inc >= 33'd4)
                    begin
                        fc_next    = '0;
                        clen_next  = '0;
                        ckind_next = '0;
                        phase_next = PH_HEAD;
                    end
                end
                PH_TAIL:
                begin
                end
                default:
                begin
                    op.handled = 1'b0;
                end
            endcase
            if (last)
            begin
                phase_next = PH_SIG;
                fc_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= 1'b0;
            file_dir_reg <= 1'b0;
            phase_reg    <= PH_SIG;
            fc_reg       <= '0;
            clen_reg     <= '0;
            ckind_reg    <= '0;
            kp_reg       <= '0;
            nlen_reg     <= '0;
            upos_reg     <= '0;
            useen_reg    <= 1'b0;
            closed_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dir_reg <= cfg_wr_data;
            end
            file_dir_reg <= file_dir_next;
            phase_reg    <= phase_next;
            fc_reg       <= fc_next;
            clen_reg     <= clen_next;
            ckind_reg    <= ckind_next;
            kp_reg       <= kp_next;
            nlen_reg     <= nlen_next;
            upos_reg     <= upos_next;
            useen_reg    <= useen_next;
            closed_reg   <= closed_next;
        end
    end

endmodule

// File: rtl/pcxs_queue.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler run queue
// Four-entry queue of byte runs between the front end and the output stage.
// ----------------------------------------------------------------------------
module pcxs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcxs_pkg::pcxs_op_t  push_op,
    output logic                full,
    input  logic                pop,
    output pcxs_pkg::pcxs_op_t  head_op,
    output logic                not_empty
);
    import pcxs_pkg::*;

    pcxs_op_t   slot_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign full      = count_reg == 3'd4;
    assign not_empty = count_reg != 3'd0;
    assign head_op   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/pcxs_back.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler output stage
// Expands queued runs into result items, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module pcxs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_avail,
    input  pcxs_pkg::pcxs_op_t  op,
    output logic                op_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                run_end,
    output logic                file_end,
    output logic                png_handled
);
    import pcxs_pkg::*;

    logic       busy_reg;
    pcxs_op_t   cur_reg;
    logic [3:0] k_reg;
    logic       last_res;

    assign last_res    = k_reg == (cur_reg.cnt - 4'd1);
    assign op_pop      = op_avail && (!busy_reg || (out_ready && last_res));
    assign out_valid   = busy_reg;
    assign out_byte    = last_res ? cur_reg.data : lead_byte(cur_reg.start + k_reg);
    assign run_end     = last_res;
    assign file_end    = last_res && cur_reg.file_last;
    assign png_handled = cur_reg.handled;

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            cur_reg <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (op_pop)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (last_res)
            begin
                busy_reg <= 1'b0;
            end
            k_reg <= k_reg + 4'd1;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cur_reg.cnt != 4'd0)
        else $error("run with no bytes");
    a_k_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> k_reg < cur_reg.cnt)
        else $error("run index past run length");
    a_run_advance: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_ready && !last_res |=> busy_reg && k_reg == $past(k_reg) + 4'd1)
        else $error("run did not advance");
`endif

endmodule

// File: rtl/png_chunk_xor_scrambler_core.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler core
// Derives a key from a name and scrambles or unscrambles PLTE and IDAT data.
// ----------------------------------------------------------------------------
// Usage: send name characters (command 0) and then file bytes (command 1) on
// the input channel; a file byte gives a run of one to twelve result items on
// the output channel, with run_end on its last item and file_end on the final
// byte of the output file. Name characters and held signature bytes give none.
// The direction register must be written through cfg_wr_en and cfg_wr_data
// only while the block is idle; this is not enforced. The direction is sampled
// at the first byte of each file. The front end accepts one item per cycle
// while its four-entry run queue has room; the output stage sends one result
// item per cycle while out_ready is high. Results pass a queue slot and the
// output register. A signature run of up to twelve items keeps the output
// stage busy; the items that follow collect in the queue and the input stalls
// once it is full. Reset clears the parser, the name length and the direction;
// the key text memories are written by the name characters. When the receiver
// stalls, runs collect in the queue and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module png_chunk_xor_scrambler_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] value,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       file_end,
    output logic       png_handled
);
    import pcxs_pkg::*;

    logic     op_push, op_full, op_pop, op_avail;
    pcxs_op_t push_op, head_op;

    pcxs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .last        (last),
        .op_push     (op_push),
        .op          (push_op),
        .op_full     (op_full)
    );

    pcxs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_op   (push_op),
        .full      (op_full),
        .pop       (op_pop),
        .head_op   (head_op),
        .not_empty (op_avail)
    );

    pcxs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_avail    (op_avail),
        .op          (head_op),
        .op_pop      (op_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .file_end    (file_end),
        .png_handled (png_handled)
    );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// PNG chunk XOR scrambler testbench
// Drives names and files through the core, predicts every output byte with a
// behavioral model of key derivation and the chunk walk, and compares results.
// ----------------------------------------------------------------------------
module testbench;

    import pcxs_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       file_end;
        logic       handled;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic       command;
    logic [7:0] value;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       file_end;
    logic       png_handled;

    result_t    expected_bytes[$];
    int         errors;
    int         cycles;
    int         hold_off;
    bit         long_hold;

    logic [7:0]  key_mem[KEY_BYTES];
    logic [7:0]  head_mem[KEY_BYTES];
    logic [7:0]  suffix_mem[KEY_BYTES];
    logic [7:0]  hold_mem[12];
    int unsigned name_len;
    int unsigned under_pos;
    bit          under_seen;
    bit          name_done;
    phase_t      phase;
    logic [31:0] field_cnt;
    logic [31:0] chunk_len;
    logic [31:0] chunk_id;
    int unsigned key_pos;
    logic        dir_reg;
    logic        file_dir;
    result_t     run_buf[$];

    png_chunk_xor_scrambler_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command), .value(value),
        .last(last), .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .run_end(run_end), .file_end(file_end), .png_handled(png_handled)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] table_byte(int i);
        logic [7:0] t[KEY_BYTES] = '{
            8'h9d, 8'hF3, 8'h00, 8'h25, 8'hef, 8'h02, 8'h77, 8'hfd, 8'he3, 8'h39,
            8'hcd, 8'h02, 8'h98, 8'h67, 8'h25, 8'hDC, 8'h10, 8'h95, 8'h68, 8'h69,
            8'h49, 8'h56, 8'h75, 8'h20, 8'h85, 8'h39, 8'h99, 8'hDF, 8'hF6, 8'h7E,
            8'h70, 8'h95, 8'he8, 8'hCC, 8'hEF, 8'h40, 8'h79, 8'h99, 8'hd1, 8'hae,
            8'h76, 8'h9F};
        return t[i];
    endfunction

    function automatic logic [7:0] lead_tbl(int i);
        logic [7:0] t[12] = '{8'h99, 8'h46, 8'hB8, 8'h0D, 8'h89, 8'h50, 8'h4E, 8'h47,
                              8'h0D, 8'h0A, 8'h1A, 8'h0A};
        return t[i];
    endfunction

    task automatic rebuild_key();
        int unsigned n;
        bit use_suffix;
        use_suffix = under_seen && (under_pos + 1 < name_len);
        n = use_suffix ? name_len - under_pos - 1 : name_len;
        for (int i = 0; i < KEY_BYTES; i++)
            key_mem[i] = table_byte(i);
        for (int i = 0; i < KEY_BYTES && i < n; i++)
            key_mem[i] = table_byte(i) ^ (use_suffix ? suffix_mem[i] : head_mem[i]);
        for (int i = 0; i < KEY_BYTES && i < n; i++)
            key_mem[KEY_BYTES-1-i] = table_byte(KEY_BYTES-1-i)
                                     ^ (use_suffix ? suffix_mem[i] : head_mem[i]);
    endtask

    task automatic push_byte(logic [7:0] b, logic h);
        run_buf.push_back('{data: b, run_end: 1'b0, file_end: 1'b0, handled: h});
    endtask

    task automatic predict_item(logic cmd, logic [7:0] v, logic lst);
        int unsigned i;
        int unsigned need;
        int unsigned base;
        logic [7:0] o;
        run_buf.delete();
        if (!cmd)
        begin
            if (name_done)
            begin
                name_len = 0;
                under_seen = 0;
                under_pos = 0;
                name_done = 0;
            end
            if (name_len < KEY_BYTES)
                head_mem[name_len] = v;
            if (!under_seen && v == UNDERSCORE)
            begin
                under_seen = 1;
                under_pos = name_len;
            end
            else if (under_seen && name_len > under_pos)
            begin
                if (name_len - under_pos - 1 < KEY_BYTES)
                    suffix_mem[name_len - under_pos - 1] = v;
            end
            if (name_len < 65535)
                name_len++;
            if (lst)
                name_done = 1;
            phase = PH_SIG;
            field_cnt = 0;
            rebuild_key();
            return;
        end
        case (phase)
            PH_SIG:
            begin
                if (field_cnt == 0)
                    file_dir = dir_reg;
                base = file_dir ? 0 : 4;
                need = file_dir ? 12 : 8;
                i = (field_cnt >= need) ? need - 1 : field_cnt;
                hold_mem[i] = v;
                field_cnt = i + 1;
                if (v != lead_tbl(base + i))
                begin
                    for (int k = 0; k < field_cnt; k++)
                        push_byte(hold_mem[k], 1'b0);
                    phase = PH_RAW;
                end
                else if (field_cnt >= need)
                begin
                    if (file_dir)
                    begin
                        for (int k = 4; k < 12; k++)
                            push_byte(hold_mem[k], 1'b1);
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            push_byte(lead_tbl(k), 1'b1);
                        for (int k = 0; k < 8; k++)
                            push_byte(hold_mem[k], 1'b1);
                    end
                    phase = PH_HEAD;
                    field_cnt = 0;
                    chunk_len = 0;
                    chunk_id = 0;
                end
                else if (lst)
                begin
                    for (int k = 0; k < field_cnt; k++)
                        push_byte(hold_mem[k], 1'b0);
                end
            end
            PH_HEAD:
            begin
                push_byte(v, 1'b1);
                if (field_cnt < 4)
                    chunk_len = {chunk_len[23:0], v};
                else
                    chunk_id = {chunk_id[23:0], v};
                field_cnt++;
                if (field_cnt >= 8)
                begin
                    field_cnt = 0;
                    key_pos = 0;
                    if (chunk_id == KIND_IDAT)
                    begin
                        if (chunk_len > IDAT_LIMIT)
                            chunk_len = IDAT_LIMIT;
                        phase = (chunk_len != 0) ? PH_DATA : PH_TAIL;
                    end
                    else
                    begin
                        phase = (chunk_len != 0) ? PH_DATA : PH_CRC;
                    end
                end
            end
            PH_DATA:
            begin
                o = v;
                if (chunk_id == KIND_PLTE || chunk_id == KIND_IDAT)
                    o = v ^ key_mem[key_pos];
                push_byte(o, 1'b1);
                key_pos = (key_pos + 1) % KEY_BYTES;
                field_cnt++;
                if (field_cnt >= chunk_len)
                begin
                    field_cnt = 0;
                    phase = (chunk_id == KIND_IDAT) ? PH_TAIL : PH_CRC;
                end
            end
            PH_CRC:
            begin
                push_byte(v, 1'b1);
                field_cnt++;
                if (field_cnt >= 4)
                begin
                    field_cnt = 0;
                    chunk_len = 0;
                    chunk_id = 0;
                    phase = PH_HEAD;
                end
            end
            PH_TAIL: push_byte(v, 1'b1);
            default: push_byte(v, 1'b0);
        endcase
        if (run_buf.size() > 0)
        begin
            run_buf[run_buf.size()-1].run_end = 1'b1;
            if (lst)
                run_buf[run_buf.size()-1].file_end = 1'b1;
        end
        if (lst)
        begin
            phase = PH_SIG;
            field_cnt = 0;
        end
        foreach (run_buf[k])
            expected_bytes.push_back(run_buf[k]);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The valid line is dropped only when a gap follows, so that back to back
    // items keep it high without a second assignment in the same step.
    task automatic send_item(logic cmd, logic [7:0] v, logic lst);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        value <= v;
        last <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(cmd, v, lst);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_direction(logic d);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dir_reg = d;
    endtask

    task automatic send_name(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i], i == s.len() - 1);
    endtask

    task automatic send_lead(logic d);
        for (int i = (d ? 0 : 4); i < 12; i++)
            send_item(1'b1, lead_tbl(i), 1'b0);
    endtask

    task automatic send_header(logic [31:0] len, logic [31:0] id);
        for (int i = 3; i >= 0; i--)
            send_item(1'b1, len[i*8 +: 8], 1'b0);
        for (int i = 3; i >= 0; i--)
            send_item(1'b1, id[i*8 +: 8], 1'b0);
    endtask

    task automatic send_chunk(logic [31:0] len, logic [31:0] id, bit final_chunk);
        send_header(len, id);
        for (int i = 0; i < len; i++)
            send_item(1'b1, 8'($urandom_range(0, 255)), final_chunk && i == len - 1);
        if (!final_chunk || len == 0)
            for (int i = 0; i < 4; i++)
                send_item(1'b1, 8'($urandom_range(0, 255)), final_chunk && i == 3);
    endtask

    task automatic test_directed();
        send_name("a_");
        send_item(1'b1, 8'h89, 1'b0);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, 8'h7E, 1'b1);
        send_item(1'b1, 8'h89, 1'b0);
        send_item(1'b1, 8'h50, 1'b1);
        send_item(1'b0, 8'h78, 1'b0);
        send_item(1'b0, UNDERSCORE, 1'b0);
        send_item(1'b0, 8'h6B, 1'b0);
        send_item(1'b0, 8'h00, 1'b1);
        send_lead(1'b0);
        send_header(32'd2, KIND_PLTE);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1);
    endtask

    task automatic test_decrypt();
        write_direction(1'b1);
        send_lead(1'b1);
        send_header(32'd0, KIND_IDAT);
        send_item(1'b1, 8'h55, 1'b1);
        send_item(1'b1, 8'h89, 1'b0);
        send_item(1'b1, 8'h50, 1'b1);
        send_item(1'b1, 8'h99, 1'b0);
        send_item(1'b1, 8'h46, 1'b0);
        send_name("_");
        write_direction(1'b0);
    endtask

    task automatic test_random_files(int budget);
        int sent;
        int n;
        logic [7:0] ch;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_direction(1'($urandom_range(0, 1)));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                begin
                    ch = ($urandom_range(0, 2) == 0) ? UNDERSCORE
                                                     : 8'($urandom_range(0, 255));
                    send_item(1'b0, ch, i == n - 1);
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(1'b1, 8'($urandom_range(0, 255)), i == n - 1);
                sent += n;
            end
            else
            begin
                send_lead(dir_reg);
                sent += dir_reg ? 12 : 8;
                if ($urandom_range(0, 1))
                    send_chunk($urandom_range(1, 6), KIND_PLTE, 0);
                if ($urandom_range(0, 2) == 0)
                    send_chunk($urandom_range(0, 3), $urandom, 0);
                n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(38, 45);
                send_chunk(n, KIND_IDAT, 1);
                sent += n + 24;
            end
        end
    endtask

    task automatic test_backpressure();
        long_hold = 1;
        send_lead(dir_reg);
        send_chunk(3, KIND_PLTE, 1);
        long_hold = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off <= 0;
        end
        else if (long_hold && hold_off == 0 && out_ready)
        begin
            out_ready <= 1'b0;
            hold_off <= 60;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= (hold_off == 1);
        end
        else
        begin
            out_ready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 30) == 0)
                hold_off <= $urandom_range(5, 20);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result byte %h", $time, out_byte);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want.data !== out_byte || want.run_end !== run_end ||
                    want.file_end !== file_end || want.handled !== png_handled)
                begin
                    $display("%0t: expected byte %h run_end %b file_end %b handled %b",
                             $time, want.data, want.run_end, want.file_end, want.handled);
                    $display("%0t: actual   byte %h run_end %b file_end %b handled %b",
                             $time, out_byte, run_end, file_end, png_handled);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 300000)
        begin
            $display("** png_chunk_xor_scrambler_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        in_valid = 0;
        command = 0;
        value = 0;
        last = 0;
        errors = 0;
        cycles = 0;
        long_hold = 0;
        dir_reg = 0;
        file_dir = 0;
        name_len = 0;
        under_pos = 0;
        under_seen = 0;
        name_done = 0;
        phase = PH_SIG;
        field_cnt = 0;
        chunk_len = 0;
        chunk_id = 0;
        key_pos = 0;
        rebuild_key();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_direction(1'b0);
        test_directed();
        test_decrypt();
        test_backpressure();
        test_random_files(50);
        wait_idle();
        if (errors == 0)
            $display("** png_chunk_xor_scrambler_core: PASSED **");
        else
            $display("** png_chunk_xor_scrambler_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/pcxs_pkg.sv
rtl/pcxs_front.sv
rtl/pcxs_queue.sv
rtl/pcxs_back.sv
rtl/png_chunk_xor_scrambler_core.sv
verif/testbench.sv
